// File: hw/rtl/fsbh_pkg.sv
// ----------------------------------------------------------------------------
// Folded string bucket hash: shared package
// Types, constants and the case-folding function used by the controller,
// the datapath and the top level.
// ----------------------------------------------------------------------------
package fsbh_pkg;

  // Bytes per accumulation group, and the width of the position counter.
  localparam int unsigned GroupLen   = 5;
  localparam int unsigned PosW       = $clog2(GroupLen + 1);
  localparam int unsigned WordW      = 32;
  localparam int unsigned DivCntW    = $clog2(WordW);
  localparam logic [WordW-1:0] BucketCountReset = 32'd1024;

  localparam logic [PosW-1:0]    GroupLenPos = PosW'(GroupLen);
  localparam logic [DivCntW-1:0] DivLastStep = DivCntW'(WordW - 1);

  // Controller states.
  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_LOAD,
    ST_DIVIDE,
    ST_FINISH
  } fsbh_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic acc_en;    // fold one accepted byte into the group
    logic load_div;  // form the total, latch the divisor, clear the key state
    logic div_step;  // one restoring division step
    logic out_load;  // move the remainder into the output register
  } fsbh_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;  // the current division step is the final one
  } fsbh_status_t;

  // Upper-case ASCII letters map to lower case; all other bytes pass.
  function automatic logic [7:0] fold_case(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if ((b >= 8'h41) && (b <= 8'h5A)) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/folded_string_bucket_hash.sv
// ----------------------------------------------------------------------------
// Folded string bucket hash: top level
// Hashes a key streamed one byte per transfer into a bucket index.
//
// Channel   Direction  Contents
// s_*       in         tdata[7:0] data_byte, tlast last_byte
// m_*       out        tdata[31:0] bucket_index
// cfg_*     in         wdata[31:0] bucket_count, written when cfg_we_i is high
//
// Key bytes are taken one per cycle, except while a finished key is being
// processed: after its last byte the block forms the total, runs the
// bit-serial divider and loads the output register, and takes no byte
// meanwhile. Asynchronous active-low reset clears the key state and sets the
// bucket count to 1024. A stalled result is held while the next key streams
// in; that key then waits in its output load stage, with intake stopped,
// until the held result has been taken.
// ----------------------------------------------------------------------------
module folded_string_bucket_hash import fsbh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,   // [7:0] data_byte
  input  logic        s_tlast_i,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [31:0] m_tdata_o,   // [31:0] bucket_index
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  fsbh_cmd_t        cmd;
  fsbh_status_t     status;
  fsbh_state_e      state;
  logic [WordW-1:0] bucket_count;

  fsbh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid_i),
    .in_last_i   (s_tlast_i),
    .in_ready_o  (s_tready_o),
    .out_ready_i (m_tready_i),
    .out_valid_o (m_tvalid_o),
    .status_i    (status),
    .cmd_o       (cmd),
    .state_o     (state)
  );

  fsbh_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .data_byte_i    (s_tdata_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .bucket_count_o (bucket_count),
    .bucket_index_o (m_tdata_o)
  );

  // The last byte of a key stops intake until the remainder is done.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o && s_tlast_i) |=> !s_tready_o)
    else $error("byte taken while the remainder is pending");

  // A presented result lies below the bucket count, or is zero for no buckets.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !cfg_we_i && !$past(cfg_we_i)) |->
      ((bucket_count == '0) ? (m_tdata_o == '0) : (m_tdata_o < bucket_count)))
    else $error("bucket index out of range");

  // The final division step leads straight to the output load stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state == ST_DIVIDE && status.div_last) |=> (state == ST_FINISH))
    else $error("divider did not finish after its last step");

endmodule

// File: hw/rtl/fsbh_ctrl.sv
// ----------------------------------------------------------------------------
// Folded string bucket hash: controller
// Sequences byte accumulation, the remainder division and the output load.
// ----------------------------------------------------------------------------
module fsbh_ctrl import fsbh_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_last_i,
  output logic         in_ready_o,
  input  logic         out_ready_i,
  output logic         out_valid_o,
  input  fsbh_status_t status_i,
  output fsbh_cmd_t    cmd_o,
  output fsbh_state_e  state_o
);

  fsbh_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  // State and output-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACCUM;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_ACCUM: begin
        in_ready_o   = 1'b1;
        cmd_o.acc_en = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.load_div = 1'b1;
        state_d        = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Wait until the output register is free before loading it.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_ACCUM;
        end
      end
      default: begin
        state_d = ST_ACCUM;
      end
    endcase
  end

  // A fresh load takes precedence over a transfer in the same cycle.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign state_o     = state_q;

endmodule

// File: hw/rtl/fsbh_datapath.sv
// ----------------------------------------------------------------------------
// Folded string bucket hash: datapath
// Group accumulator, running total, bucket count register, a bit-serial
// restoring divider for the remainder and the output register.
// ----------------------------------------------------------------------------
module fsbh_datapath import fsbh_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fsbh_cmd_t        cmd_i,
  output fsbh_status_t     status_o,
  input  logic [7:0]       data_byte_i,
  input  logic             cfg_we_i,
  input  logic [WordW-1:0] cfg_wdata_i,
  output logic [WordW-1:0] bucket_count_o,
  output logic [WordW-1:0] bucket_index_o
);

  logic [WordW-1:0]   group_q, group_d;
  logic [WordW-1:0]   total_q, total_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [WordW-1:0]   bucket_count_q;
  logic [WordW-1:0]   divisor_q;
  logic [WordW-1:0]   dvd_q;
  logic [WordW-1:0]   rem_q;
  logic [DivCntW-1:0] cnt_q;
  logic [WordW-1:0]   index_q;

  logic [WordW-1:0] eff_group;
  logic [WordW-1:0] eff_total;
  logic             group_full;
  logic [WordW:0]   rem_sh;
  logic [WordW:0]   rem_diff;

  // Bucket count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= BucketCountReset;
    end else if (cfg_we_i) begin
      bucket_count_q <= cfg_wdata_i;
    end
  end

  // A full group is folded into the total before the new byte starts a group.
  assign group_full = (pos_q >= GroupLenPos);
  assign eff_group  = group_full ? '0 : group_q;
  assign eff_total  = group_full ? (total_q + group_q) : total_q;

  always_comb begin
    group_d = group_q;
    total_d = total_q;
    pos_d   = pos_q;
    if (cmd_i.load_div) begin
      group_d = '0;
      total_d = '0;
      pos_d   = '0;
    end else if (cmd_i.acc_en) begin
      group_d = eff_group + (eff_group << 3) + {{(WordW-8){1'b0}}, fold_case(data_byte_i)};
      total_d = eff_total;
      pos_d   = group_full ? PosW'(1) : (pos_q + PosW'(1));
    end
  end

  // Key accumulation state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= '0;
      total_q <= '0;
      pos_q   <= '0;
    end else begin
      group_q <= group_d;
      total_q <= total_d;
      pos_q   <= pos_d;
    end
  end

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign rem_sh   = {rem_q, dvd_q[WordW-1]};
  assign rem_diff = rem_sh - {1'b0, divisor_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load_div) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + DivCntW'(1);
    end
  end

  // Divider registers and the output register hold payload only.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_div) begin
      dvd_q     <= total_q + group_q;
      rem_q     <= '0;
      divisor_q <= bucket_count_q;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[WordW-2:0], 1'b0};
      rem_q <= rem_diff[WordW] ? rem_sh[WordW-1:0] : rem_diff[WordW-1:0];
    end
    if (cmd_i.out_load) begin
      index_q <= (divisor_q == '0) ? '0 : rem_q;
    end
  end

  assign status_o.div_last = (cnt_q == DivLastStep);
  assign bucket_count_o    = bucket_count_q;
  assign bucket_index_o    = index_q;

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Folded string bucket hash: self-checking testbench
// Streams keys into the block one byte per transfer and keeps its own model
// of the case-folded group hash to predict every bucket index. Results are
// compared in order as they leave the block. The run covers several bucket
// counts, including the extremes, and several patterns of sender gaps and
// receiver back-pressure.
// ----------------------------------------------------------------------------
module tb;
  import fsbh_pkg::*;

  // Settling time for the block after a last byte, with a margin.
  localparam int unsigned DrainCycles  = 40;
  localparam int unsigned PhaseBytes   = 305;
  localparam int unsigned LongHoldLen  = 400;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } key_byte_t;

  // Block ports.
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        s_tvalid_i  = 1'b0;
  logic        s_tready_o;
  logic [7:0]  s_tdata_i   = 8'h00;   // [7:0] data_byte
  logic        s_tlast_i   = 1'b0;
  logic        m_tvalid_o;
  logic        m_tready_i  = 1'b0;
  logic [31:0] m_tdata_o;             // [31:0] bucket_index
  logic        cfg_we_i    = 1'b0;
  logic [31:0] cfg_wdata_i = 32'd0;

  // Bytes waiting to be sent, and bucket indices waiting to arrive.
  key_byte_t   key_bytes_q[$];
  logic [31:0] expected_buckets_q[$];

  // Own copy of the hash state and the bucket count.
  logic [31:0] grp_acc    = 32'd0;
  logic [31:0] run_total  = 32'd0;
  int unsigned grp_pos    = 0;
  logic [31:0] bucket_cnt = BucketCountReset;

  // Idling controls, set per phase.
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  logic        rx_hold_req  = 1'b0;
  int unsigned rx_hold_left = 0;

  int unsigned fail_cnt = 0;

  folded_string_bucket_hash DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tlast_i  (s_tlast_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // Fold one accepted byte into the predicted state; a last byte yields
  // the expected bucket index and clears the key state.
  task automatic fold_hash_byte(input logic [7:0] b, input logic lst);
    logic [7:0]  folded;
    logic [31:0] total;
    folded = ((b >= 8'h41) && (b <= 8'h5A)) ? b + 8'h20 : b;
    if (grp_pos >= GroupLen) begin
      run_total = run_total + grp_acc;
      grp_acc   = 32'd0;
      grp_pos   = 0;
    end
    grp_acc = grp_acc * 32'd9 + {24'd0, folded};
    grp_pos++;
    if (lst) begin
      total = run_total + grp_acc;
      expected_buckets_q.push_back((bucket_cnt == 32'd0) ? 32'd0 : total % bucket_cnt);
      grp_acc   = 32'd0;
      run_total = 32'd0;
      grp_pos   = 0;
    end
  endtask

  function automatic void push_byte(input logic [7:0] b, input logic lst);
    key_byte_t kb;
    kb.data = b;
    kb.last = lst;
    key_bytes_q.push_back(kb);
  endfunction

  // Key bytes lean towards letters and the values around the folding range.
  function automatic logic [7:0] random_key_byte();
    int unsigned r;
    logic [7:0]  edges[6];
    edges = '{8'h40, 8'h5B, 8'h60, 8'h7B, 8'h00, 8'hFF};
    r = $urandom_range(99);
    if (r < 35) return 8'($urandom_range(8'h41, 8'h5A));
    if (r < 55) return 8'($urandom_range(8'h61, 8'h7A));
    if (r < 65) return edges[$urandom_range(5)];
    return 8'($urandom_range(255));
  endfunction

  // Queue one whole key of random length and return its length.
  function automatic int unsigned push_random_key();
    int unsigned r;
    int unsigned len;
    r = $urandom_range(99);
    if (r < 70)      len = $urandom_range(1, 12);
    else if (r < 95) len = $urandom_range(13, 30);
    else             len = $urandom_range(31, 64);
    for (int unsigned i = 0; i < len; i++) begin
      push_byte(random_key_byte(), i == len - 1);
    end
    return len;
  endfunction

  // Wait until every queued byte has gone and every result has come,
  // then give the block time to finish any work still under way.
  task automatic wait_drained();
    while (key_bytes_q.size() != 0 || s_tvalid_i || expected_buckets_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_bucket_count(input logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    bucket_cnt  = value;
  endtask

  // Input driver: a transfer completes when valid and ready are both high;
  // an offered byte stays until it is taken.
  always @(posedge clk_i) begin : driver
    logic offer;
    offer = 1'b0;
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_o) begin
        fold_hash_byte(s_tdata_i, s_tlast_i);
        void'(key_bytes_q.pop_front());
      end else if (s_tvalid_i) begin
        offer = 1'b1;
      end
      if (!offer && key_bytes_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        offer = 1'b1;
      end
    end
    s_tvalid_i <= offer;
    if (offer) begin
      s_tdata_i <= key_bytes_q[0].data;
      s_tlast_i <= key_bytes_q[0].last;
    end
  end

  // Long receiver hold-off, counted here so the monitor only reads it.
  always @(posedge clk_i) begin
    if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_req) begin
      rx_hold_left <= LongHoldLen;
    end
  end

  // Output monitor: check each result transfer against the oldest prediction.
  always @(posedge clk_i) begin : monitor
    logic [31:0] want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (expected_buckets_q.size() == 0) begin
        $error("bucket_index: expected none, got %0d", m_tdata_o);
        fail_cnt++;
      end else begin
        want = expected_buckets_q.pop_front();
        if (m_tdata_o !== want) begin
          $error("bucket_index: expected %0d, got %0d", want, m_tdata_o);
          fail_cnt++;
        end
      end
    end
    m_tready_i <= rst_ni && (rx_hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
  end

  // Stimulus: directed keys first, then random phases.
  initial begin : stimulus
    int unsigned phase;
    int unsigned sent;
    logic        hold_done;
    logic        pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Single-byte keys at the reset bucket count: extremes and case folding.
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte("A", 1'b1);
    push_byte("Z", 1'b1);
    push_byte(8'h40, 1'b1);
    push_byte(8'h5B, 1'b1);
    // Exactly one full group, then one byte past the group boundary.
    push_byte("H", 1'b0); push_byte("e", 1'b0); push_byte("L", 1'b0);
    push_byte("l", 1'b0); push_byte("O", 1'b1);
    push_byte("Q", 1'b0); push_byte("u", 1'b0); push_byte("E", 1'b0);
    push_byte("r", 1'b0); push_byte("Y", 1'b0); push_byte(8'hFF, 1'b1);
    wait_drained();

    // A zero bucket count gives index zero.
    write_bucket_count(32'd0);
    push_byte("k", 1'b0);
    push_byte(8'h7E, 1'b1);
    wait_drained();

    // A new bucket count written mid key applies to that key's remainder.
    write_bucket_count(32'hFFFF_FFFF);
    push_byte("M", 1'b0);
    push_byte("i", 1'b0);
    wait_drained();
    write_bucket_count(32'd37);
    push_byte("D", 1'b1);

    for (phase = 0; phase < 6; phase++) begin
      wait_drained();
      case (phase)
        0: write_bucket_count(32'd1);
        1: write_bucket_count(32'hFFFF_FFFF);
        2: write_bucket_count(32'($urandom_range(2, 1000)));
        3: write_bucket_count($urandom() | 32'h8000_0000);
        4: write_bucket_count(32'd1 << $urandom_range(0, 31));
        default: write_bucket_count(32'($urandom_range(2, 65536)));
      endcase
      case (phase % 4)
        0: begin tx_idle_pct <= 0;  rx_stall_pct <= 0;  end
        1: begin tx_idle_pct <= 59; rx_stall_pct <= 0;  end
        2: begin tx_idle_pct <= 0;  rx_stall_pct <= 59; end
        default: begin tx_idle_pct <= 10; rx_stall_pct <= 10; end
      endcase
      sent = 0;
      while (sent < PhaseBytes) begin
        sent += push_random_key();
        // Hold the receiver off while the sender keeps offering bytes.
        if (phase == 4 && !hold_done && sent >= 60) begin
          @(posedge clk_i);
          rx_hold_req <= 1'b1;
          @(posedge clk_i);
          rx_hold_req <= 1'b0;
          hold_done = 1'b1;
        end
        // Let the sender rest until every outstanding result is back.
        if (phase == 2 && !pause_done && sent >= PhaseBytes / 2) begin
          wait_drained();
          pause_done = 1'b1;
        end
      end
    end
    wait_drained();

    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog, several times the slowest correct run.
  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/fsbh_pkg.sv
hw/rtl/fsbh_ctrl.sv
hw/rtl/fsbh_datapath.sv
hw/rtl/folded_string_bucket_hash.sv
tb/sv/tb.sv
